// ===== sv/tccs_pkg.sv =====
// Shared constants and types for the text console cursor and scroll engine.
// No dependencies; tccs_cursor and text_console_cursor_scroll import this package.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths of the stream items.
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 11;
    localparam int CELL_W      = 16;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int COLOR_W     = 8;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Character codes and cursor constants.
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
    localparam int                 TAB_EXTRA   = 5;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd15;
    localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_SPACE};
    localparam logic [CELL_W-1:0]  BLANK_CELL  = '0;

    // Item kinds carried in s_tuser.
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // A put item handed to the cursor unit.
    typedef struct packed {
        logic              fire;
        logic [CHAR_W-1:0] char_code;
    } tccs_put_t;

    // Cursor report: the position now and after the pending put item.
    typedef struct packed {
        logic [ROW_OUT_W-1:0] cur_row;
        logic [COL_OUT_W-1:0] cur_col;
        logic [ROW_OUT_W-1:0] nxt_row;
        logic [COL_OUT_W-1:0] nxt_col;
        logic                 nxt_scroll;
    } tccs_cursor_t;

endpackage

`default_nettype wire

// ===== sv/tccs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tccs_cursor.sv =====
// Cursor unit: row, column, line offset and the circular screen base.
// Depends on tccs_pkg for the character codes and the report struct.
`timescale 1ns / 1ps
`default_nettype none

module tccs_cursor
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tccs_put_t         put,
    output tccs_cursor_t           report,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [ADDR_W-1:0] base
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int CX_W  = COL_W + 1;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] line_reg, line_next;   // physical-free offset row * COLUMNS
    logic [ADDR_W-1:0] base_reg, base_next;   // offset of the top row in memory
    logic              scroll;

    // Cursor advance for the pending put item.
    always_comb begin
        logic [CX_W-1:0]   col1;
        logic [CX_W-1:0]   col2;
        logic              new_line;
        logic [ADDR_W:0]   base_sum;
        col1      = CX_W'(col_reg) + CX_W'(1);
        col2      = col1 + CX_W'(TAB_EXTRA);
        new_line  = 1'b0;
        row_next  = row_reg;
        col_next  = col_reg;
        line_next = line_reg;
        base_next = base_reg;
        scroll    = 1'b0;
        if (col1 >= CX_W'(COLUMNS) || put.char_code == CH_NEWLINE) begin
            new_line = 1'b1;
        end else if (put.char_code == CH_TAB) begin
            if (col2 >= CX_W'(COLUMNS)) begin
                new_line = 1'b1;
            end else begin
                col_next = col2[COL_W-1:0];
            end
        end else begin
            col_next = col1[COL_W-1:0];
        end
        // Next line, scrolling by moving the base one row on.
        base_sum = (ADDR_W+1)'(base_reg) + (ADDR_W+1)'(COLUMNS);
        if (new_line) begin
            col_next = '0;
            if (row_reg == ROW_W'(ROWS - 1)) begin
                scroll = 1'b1;
                if (base_sum >= (ADDR_W+1)'(CELLS)) begin
                    base_next = '0;
                end else begin
                    base_next = base_sum[ADDR_W-1:0];
                end
            end else begin
                row_next  = row_reg + ROW_W'(1);
                line_next = line_reg + ADDR_W'(COLUMNS);
            end
        end
    end

    // Cursor registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            line_reg <= '0;
            base_reg <= '0;
        end else if (put.fire) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            line_reg <= line_next;
            base_reg <= base_next;
        end
    end

    // Memory address of the cursor cell, wrapped around the screen ring.
    always_comb begin
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(line_reg) + (ADDR_W+1)'(col_reg) + (ADDR_W+1)'(base_reg);
        if (sum >= (ADDR_W+1)'(CELLS)) begin
            sum = sum - (ADDR_W+1)'(CELLS);
        end
        wr_addr = sum[ADDR_W-1:0];
    end

    assign base = base_reg;

    // Report positions as the low bits of the cursor coordinates.
    always_comb begin
        logic [31:0] cr;
        logic [31:0] cc;
        logic [31:0] nr;
        logic [31:0] nc;
        cr = 32'(row_reg);
        cc = 32'(col_reg);
        nr = 32'(row_next);
        nc = 32'(col_next);
        report.cur_row    = cr[ROW_OUT_W-1:0];
        report.cur_col    = cc[COL_OUT_W-1:0];
        report.nxt_row    = nr[ROW_OUT_W-1:0];
        report.nxt_col    = nc[COL_OUT_W-1:0];
        report.nxt_scroll = scroll;
    end

endmodule

`default_nettype wire

// ===== sv/text_console_cursor_scroll.sv =====
// Text console engine: screen memory as a ring of rows, cursor and scroll.
// Depends on tccs_pkg, tccs_ram and tccs_cursor.
// Put results are registered on acceptance, read results in ST_READ. Throughput: one
// put item per cycle while idle and the output is not stalled; a read item holds off
// new items in ST_READ; a scroll adds a sweep zeroing the new bottom row via the single
// write port. Reset: a clearing pass fills all ROWS * COLUMNS cells (2000 by default).
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration: text_color.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    // Input items.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero
    input  wire logic                 s_tuser,   // kind
    // Result items.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // cell_data[15:0], cursor_row[20:16],
                                                 // cursor_col[27:21], scrolled[28], zero
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SUM_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_SWEEP = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [COLOR_W-1:0]    color_reg;
    logic [ADDR_W-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]     sweep_last_reg, sweep_last_next;
    logic                  oor_reg, oor_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [CHAR_W-1:0]     char_code;
    logic [IDX_W-1:0]      cell_index;
    logic                  accept;
    tccs_put_t             put;
    tccs_cursor_t          report;
    logic [ADDR_W-1:0]     cur_addr;
    logic [ADDR_W-1:0]     base;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [CELL_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [CELL_W-1:0]     mem_rdata;
    logic                  idx_in_range;

    assign char_code  = s_tdata[CHAR_W-1:0];
    assign cell_index = s_tdata[CHAR_W+IDX_W-1:CHAR_W];
    assign s_tready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    assign put.fire      = accept && (s_tuser == KIND_PUT);
    assign put.char_code = char_code;

    tccs_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .put     (put),
        .report  (report),
        .wr_addr (cur_addr),
        .base    (base)
    );

    // Read address: logical cell index rotated by the ring base.
    always_comb begin
        logic [SUM_W-1:0] sum;
        idx_in_range = SUM_W'(cell_index) < SUM_W'(CELLS);
        sum = SUM_W'(cell_index) + SUM_W'(base);
        if (sum >= SUM_W'(CELLS)) begin
            sum = sum - SUM_W'(CELLS);
        end
        mem_raddr = sum[ADDR_W-1:0];
    end

    // Write port: clearing sweeps, or the put character at the cursor.
    always_comb begin
        logic [CHAR_W-1:0] stored;
        stored    = (char_code == CH_NEWLINE || char_code == CH_TAB) ? CH_SPACE : char_code;
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = {color_reg, stored};
        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = RESET_CELL;
            end
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = BLANK_CELL;
            end
            ST_IDLE: begin
                mem_we = put.fire;
            end
            ST_READ: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer and result register.
    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        oor_next        = oor_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            ST_INIT, ST_SWEEP: begin
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_READ) begin
                        oor_next   = !idx_in_range;
                        state_next = ST_READ;
                    end else begin
                        out_valid_next = 1'b1;
                        out_data_next  = M_TDATA_W'({report.nxt_scroll, report.nxt_col,
                                                     report.nxt_row, BLANK_CELL});
                        if (report.nxt_scroll) begin
                            // The old top row becomes the new bottom row.
                            sweep_addr_next = base;
                            sweep_last_next = base + ADDR_W'(COLUMNS - 1);
                            state_next      = ST_SWEEP;
                        end
                    end
                end
            end
            ST_READ: begin
                out_valid_next = 1'b1;
                out_data_next  = M_TDATA_W'({1'b0, report.cur_col, report.cur_row,
                                             oor_reg ? BLANK_CELL : mem_rdata});
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_W'(CELLS - 1);
            out_valid_reg  <= 1'b0;
            color_reg      <= RESET_COLOR;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                color_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        oor_reg      <= oor_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
